// ===== rtl/cmsp_pkg.sv =====
// Package for the multiples-of-small-primes counter: widths, constant prime
// product tables, divider stage type and the sequencer state type.
// No dependencies.
package cmsp_pkg;

   localparam int BOUND_W   = 62;
   localparam int PROD_W    = 60;
   localparam int LO_W      = 24;
   localparam int HI_W      = 36;
   localparam int SUBSET_W  = 15;
   localparam int LO_BITS   = 8;
   localparam int HI_BITS   = 7;
   localparam int DIV_STAGES = BOUND_W;
   localparam logic [3:0] PRIME_COUNT_RESET = 4'd10;

   typedef logic [5:0] prime_tab_type [SUBSET_W];
   typedef logic [LO_W-1:0] lo_tab_type [2**LO_BITS];
   typedef logic [HI_W-1:0] hi_tab_type [2**HI_BITS];

   localparam prime_tab_type PRIMES = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17,
      6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47};

   // Product of the primes selected by each low index (primes 2 through 19).
   function automatic lo_tab_type build_lo_tab();
      lo_tab_type t;
      longint     p;
      for (int i = 0; i < 2**LO_BITS; i++) begin
         p = 1;
         for (int j = 0; j < LO_BITS; j++) begin
            if (((i >> j) & 1) == 1) begin
               p = p * longint'(PRIMES[j]);
            end
         end
         t[i] = LO_W'(p);
      end
      return t;
   endfunction

   // Product of the primes selected by each high index (primes 23 through 47).
   function automatic hi_tab_type build_hi_tab();
      hi_tab_type t;
      longint     p;
      for (int i = 0; i < 2**HI_BITS; i++) begin
         p = 1;
         for (int j = 0; j < HI_BITS; j++) begin
            if (((i >> j) & 1) == 1) begin
               p = p * longint'(PRIMES[LO_BITS + j]);
            end
         end
         t[i] = HI_W'(p);
      end
      return t;
   endfunction

   localparam lo_tab_type LO_TAB = build_lo_tab();
   localparam hi_tab_type HI_TAB = build_hi_tab();

   typedef struct packed {
      logic                valid;
      logic                last;
      logic                neg;
      logic [PROD_W-1:0]   rem;
      logic [BOUND_W-1:0]  num;
      logic [BOUND_W-1:0]  quo;
      logic [PROD_W-1:0]   dvs;
   } div_stage_type;

   // One restoring division step: one quotient bit.
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type r;
      logic [PROD_W:0] t;
      logic            ge;
      r  = s;
      t  = {s.rem, s.num[BOUND_W-1]};
      ge = (t >= {1'b0, s.dvs});
      r.rem = ge ? PROD_W'(t - {1'b0, s.dvs}) : t[PROD_W-1:0];
      r.num = {s.num[BOUND_W-2:0], 1'b0};
      r.quo = {s.quo[BOUND_W-2:0], ge};
      return r;
   endfunction

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_HOLD
   } cmsp_state_type;

endpackage

// ===== rtl/cmsp_if.sv =====
// Valid/ready channel interfaces for the bound requests and count responses.
// Depends on cmsp_pkg.
interface cmsp_req_if import cmsp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BOUND_W-1:0] bound;
   modport source (output valid, output bound, input ready);
   modport sink   (input valid, input bound, output ready);
endinterface

interface cmsp_rsp_if import cmsp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BOUND_W-1:0] multiple_count;
   modport source (output valid, output multiple_count, input ready);
   modport sink   (input valid, input multiple_count, output ready);
endinterface

// ===== rtl/cmsp_divider.sv =====
// Fully pipelined restoring divider, one quotient bit per stage.
// Depends on cmsp_pkg.
module cmsp_divider import cmsp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type in_s,
   output div_stage_type out_s
);

   div_stage_type st_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else begin
         st_ff[0] <= div_step(in_s);
         for (int i = 1; i < DIV_STAGES; i++) begin
            st_ff[i] <= div_step(st_ff[i-1]);
         end
      end
   end

   assign out_s = st_ff[DIV_STAGES-1];

endmodule

// ===== rtl/count_multiples_of_small_primes.sv =====
// Counts integers in 1..bound divisible by any of the first k primes, where
// k is capped at MAX_PRIMES. One subset enters the divider pipeline each
// cycle, so the response time grows with the subset count 2^k - 1. One bound
// is worked on at a time: a new transaction is taken only after the previous
// response has been loaded into the output register.
// Synchronous active-high reset clears control state and sets k to 10.
module count_multiples_of_small_primes import cmsp_pkg::*; #(
   parameter int MAX_PRIMES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [3:0]  csr_wdata,
   cmsp_req_if.sink    req_ch,
   cmsp_rsp_if.source  rsp_ch
);

   localparam int CW = MAX_PRIMES + 1;

   cmsp_state_type     state_ff, state_in;
   logic [3:0]         k_ff;
   logic [3:0]         k_eff;
   logic [BOUND_W-1:0] bound_ff;
   logic [CW-1:0]      subset_ff, subset_in;
   logic [CW-1:0]      last_sub;
   logic [SUBSET_W-1:0] sub15;
   logic [BOUND_W-1:0] acc_ff, acc_in;
   logic [BOUND_W-1:0] out_ff;
   logic               out_valid_ff, out_valid_in;
   logic               load_out;
   logic               accept;
   logic               issue;

   logic               s0_valid_ff, s0_last_ff, s0_neg_ff;
   logic [LO_W-1:0]    s0_lo_ff;
   logic [HI_W-1:0]    s0_hi_ff;
   div_stage_type      s1_ff;
   div_stage_type      div_out;

   assign k_eff    = (k_ff > 4'(MAX_PRIMES)) ? 4'(MAX_PRIMES) : k_ff;
   assign last_sub = ({{(CW-1){1'b0}}, 1'b1} << k_eff) - {{(CW-1){1'b0}}, 1'b1};
   assign sub15    = SUBSET_W'(subset_ff);
   assign accept   = req_ch.valid && req_ch.ready;
   assign issue    = (state_ff == ST_RUN);
   assign load_out = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_ch.ready);

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.multiple_count = out_ff;

   always_comb begin
      state_in  = state_ff;
      subset_in = subset_ff;
      acc_in    = acc_ff;
      if (div_out.valid) begin
         acc_in = div_out.neg ? acc_ff - div_out.quo : acc_ff + div_out.quo;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               acc_in    = '0;
               subset_in = {{(CW-1){1'b0}}, 1'b1};
               state_in  = (k_eff == 4'd0) ? ST_HOLD : ST_RUN;
            end
         end
         ST_RUN: begin
            subset_in = subset_ff + {{(CW-1){1'b0}}, 1'b1};
            if (subset_ff == last_sub) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (div_out.valid && div_out.last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load_out || (out_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= PRIME_COUNT_RESET;
         out_valid_ff <= 1'b0;
         s0_valid_ff  <= 1'b0;
         s1_ff.valid  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_write) begin
            k_ff <= csr_wdata;
         end
         // Table lookup stage: split the subset into low and high prime groups.
         s0_valid_ff <= issue;
         s0_last_ff  <= (subset_ff == last_sub);
         s0_neg_ff   <= !(^sub15);
         s0_lo_ff    <= LO_TAB[sub15[LO_BITS-1:0]];
         s0_hi_ff    <= HI_TAB[sub15[SUBSET_W-1:LO_BITS]];
         // Multiply stage: the full subset product, then into the divider.
         s1_ff.valid <= s0_valid_ff;
         s1_ff.last  <= s0_last_ff;
         s1_ff.neg   <= s0_neg_ff;
         s1_ff.rem   <= '0;
         s1_ff.num   <= bound_ff;
         s1_ff.quo   <= '0;
         s1_ff.dvs   <= PROD_W'(s0_lo_ff * s0_hi_ff);
      end
   end

   always_ff @(posedge clock) begin
      subset_ff <= subset_in;
      acc_ff    <= acc_in;
      if (accept) begin
         bound_ff <= req_ch.bound;
      end
      if (load_out) begin
         out_ff <= acc_ff;
      end
   end

   cmsp_divider u_divider (
      .clock (clock),
      .reset (reset),
      .in_s  (s1_ff),
      .out_s (div_out)
   );

endmodule

// ===== rtl/cmsp_checker.sv =====
// Port-level checks for the multiples-of-small-primes counter, bound to the
// top level. Depends on cmsp_pkg and count_multiples_of_small_primes.
module cmsp_checker import cmsp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [BOUND_W-1:0] rsp_multiple_count
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only one bound is in work at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after a transaction");

   // A stalled response holds its count.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_multiple_count)))
      else $error("stalled response changed");

endmodule

bind count_multiples_of_small_primes cmsp_checker u_cmsp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_multiple_count (rsp_ch.multiple_count)
);
